// ----- rtl/dab_fig0_3_record_parser_defines.svh -----
// Assertion macros for the DAB FIG 0/3 record parser.
// Define NO_ASSERTIONS to compile them out; uses clk and rst_n of the including module.
`ifndef DAB_FIG0_3_RECORD_PARSER_DEFINES_SVH
`define DAB_FIG0_3_RECORD_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DABF03_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dabf03: property failed");
`define DABF03_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dabf03: forbidden condition");
`else
`define DABF03_ASSERT(label, prop)
`define DABF03_NEVER(label, expr)
`endif
`endif

// ----- rtl/dabf03_pkg.sv -----
// Types and constants for the DAB FIG 0/3 record parser.
// No dependencies.
package dabf03_pkg;

    localparam int ID_W       = 12;
    localparam int ID_COUNT   = 1 << ID_W;
    localparam int EPOCH_W    = ID_W + 1;
    localparam int REC_W      = 40;
    localparam int OUT_TDATA_W = 64;

    localparam logic [2:0] ID_READ_POS  = 3'd1;
    localparam logic [2:0] REC_LAST_POS = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [EPOCH_W-1:0] tag;
    } seen_entry_t;

    localparam int ENTRY_W = $bits(seen_entry_t);

    typedef struct packed {
        logic        repeat_seen;
        logic        shared_zero;
        logic        ca_length_error;
        logic [15:0] ca_word;
        logic        rfu_value;
        logic [2:0]  rfa_value;
        logic [9:0]  pkt_addr;
        logic [5:0]  subchannel_id;
        logic [5:0]  component_type;
        logic        dg_flag;
        logic        ca_flag;
        logic [11:0] component_id;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/dabf03_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
module dabf03_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dab_fig0_3_record_parser.sv -----
// DAB FIG 0/3 record parser top level; uses dabf03_pkg, dabf03_ram and the defines header.
// Takes one byte per cycle, back to back, while s_tready is high; a record result is registered
// into the output stage, or the skid register while the output stalls. Seen-set: 4096-entry
// epoch-tagged RAM; a one-read, at-most-one-write scrub trails each lookup. Reset is async:
// parser and output stage clear at once, then a pass clears every RAM entry with s_tready low.
`include "dab_fig0_3_record_parser_defines.svh"

module dab_fig0_3_record_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // component_id, ca_flag, dg_flag, component_type,
                                   // subchannel_id, pkt_addr, rfa_value, rfu_value,
                                   // ca_word, ca_length_error, shared_zero, repeat_seen
);

    import dabf03_pkg::*;

    logic [2:0]         pos_reg, pos_next;
    logic [REC_W-1:0]   rec_reg, rec_next, rec_cur;
    logic [7:0]         cahi_reg, cahi_next;
    logic               await_reg, await_next;
    logic               prep_reg, prep_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    logic               clr_busy_reg;
    logic [ID_W-1:0]    clr_addr_reg;
    logic               scr1_reg, scr2_reg;
    logic [ID_W-1:0]    scrub_ptr_reg;

    logic               out_valid_reg, skid_valid_reg;
    result_t            out_data_reg, skid_data_reg;

    logic               fire, out_free;
    logic               lookup_rd, lookup_wr, scrub_wr, seen;
    logic               res_valid, res_rep, res_err, res_shz;
    logic [15:0]        res_ca;
    result_t            res;

    logic               ram_we, ram_re;
    logic [ID_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    seen_entry_t        rd_entry, wr_entry;

    assign s_tready = !clr_busy_reg && !skid_valid_reg;
    assign fire     = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_entry = ram_rdata;
    assign seen     = rd_entry.valid && (rd_entry.tag == epoch_reg);
    assign rec_cur  = await_reg ? rec_reg : {rec_reg[REC_W-9:0], s_tdata};

    always_comb
    begin
        pos_next   = pos_reg;
        rec_next   = rec_reg;
        cahi_next  = cahi_reg;
        await_next = await_reg;
        prep_next  = prep_reg;
        epoch_next = epoch_reg;
        lookup_rd  = 1'b0;
        lookup_wr  = 1'b0;
        res_valid  = 1'b0;
        res_rep    = 1'b0;
        res_err    = 1'b0;
        res_shz    = 1'b0;
        res_ca     = 16'd0;
        if (fire)
        begin
            if (s_tuser)
            begin
                pos_next   = 3'd0;
                rec_next   = '0;
                cahi_next  = 8'd0;
                await_next = 1'b0;
                prep_next  = 1'b0;
            end
            else if (await_reg)
            begin
                res_rep = prep_reg;
                if (pos_reg == 3'd0)
                begin
                    cahi_next = s_tdata;
                    pos_next  = 3'd1;
                    if (s_tlast)
                    begin
                        res_valid  = 1'b1;
                        res_err    = 1'b1;
                        pos_next   = 3'd0;
                        rec_next   = '0;
                        cahi_next  = 8'd0;
                        await_next = 1'b0;
                        prep_next  = 1'b0;
                    end
                end
                else
                begin
                    res_valid  = 1'b1;
                    res_ca     = {cahi_reg, s_tdata};
                    res_shz    = (s_tdata == 8'd0);
                    pos_next   = 3'd0;
                    rec_next   = '0;
                    cahi_next  = 8'd0;
                    await_next = 1'b0;
                    prep_next  = 1'b0;
                end
            end
            else
            begin
                rec_next = rec_cur;
                pos_next = pos_reg + 3'd1;
                if (pos_reg == ID_READ_POS)
                begin
                    lookup_rd = 1'b1;
                end
                if (pos_reg == REC_LAST_POS)
                begin
                    lookup_wr = 1'b1;
                    pos_next  = 3'd0;
                    res_rep   = seen;
                    if (seen)
                    begin
                        epoch_next = epoch_reg + {{(EPOCH_W-1){1'b0}}, 1'b1};
                    end
                    if (rec_cur[24] && !s_tlast)
                    begin
                        await_next = 1'b1;
                        prep_next  = seen;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_err   = rec_cur[24];
                    end
                end
                if (s_tlast)
                begin
                    pos_next   = 3'd0;
                    rec_next   = '0;
                    cahi_next  = 8'd0;
                    await_next = 1'b0;
                    prep_next  = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        res.component_id    = rec_cur[39:28];
        res.ca_flag         = rec_cur[24];
        res.dg_flag         = rec_cur[23];
        res.component_type  = rec_cur[21:16];
        res.subchannel_id   = rec_cur[15:10];
        res.pkt_addr        = rec_cur[9:0];
        res.rfa_value       = rec_cur[27:25];
        res.rfu_value       = rec_cur[22];
        res.ca_word         = res_ca;
        res.ca_length_error = res_err;
        res.shared_zero     = res_shz;
        res.repeat_seen     = res_rep;
    end

    // seen-set port steering; lookup and scrub slots never coincide
    assign scrub_wr       = scr2_reg && rd_entry.valid && (rd_entry.tag != epoch_reg);
    assign wr_entry.valid = lookup_wr;
    assign wr_entry.tag   = lookup_wr ? epoch_next : '0;
    assign ram_we         = clr_busy_reg || lookup_wr || scrub_wr;
    assign ram_waddr      = clr_busy_reg ? clr_addr_reg :
                            (lookup_wr ? rec_cur[39:28] : scrub_ptr_reg);
    assign ram_wdata      = wr_entry;
    assign ram_re         = lookup_rd || scr1_reg;
    assign ram_raddr      = lookup_rd ? {rec_reg[7:0], s_tdata[7:4]} : scrub_ptr_reg;

    dabf03_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ID_COUNT)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 3'd0;
            await_reg      <= 1'b0;
            prep_reg       <= 1'b0;
            epoch_reg      <= '0;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            scr1_reg       <= 1'b0;
            scr2_reg       <= 1'b0;
            scrub_ptr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            await_reg <= await_next;
            prep_reg  <= prep_next;
            epoch_reg <= epoch_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + {{(ID_W-1){1'b0}}, 1'b1};
                if (clr_addr_reg == {ID_W{1'b1}})
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            scr1_reg <= lookup_wr;
            scr2_reg <= scr1_reg;
            if (scr2_reg)
            begin
                scrub_ptr_reg <= scrub_ptr_reg + {{(ID_W-1){1'b0}}, 1'b1};
            end
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        cahi_reg <= cahi_next;
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_data_reg};

    `DABF03_NEVER(a_rd_port_clash, lookup_rd && scr1_reg)
    `DABF03_NEVER(a_wr_port_clash, lookup_wr && (scrub_wr || clr_busy_reg))
    `DABF03_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg)
    `DABF03_ASSERT(a_epoch_step, (epoch_reg != $past(epoch_reg)) |-> $past(lookup_wr))

endmodule

// ----- tb/dab_fig0_3_record_parser_tb.sv -----
// Testbench for the DAB FIG 0/3 record parser: directed and random FIG streams with idling.
// Depends on dabf03_pkg and dab_fig0_3_record_parser; self-checking against an internal model.
module dab_fig0_3_record_parser_tb;
    import dabf03_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;
    int beats_sent  = 0;
    int error_count = 0;
    int stall_cycles = 0;

    // parser model state
    logic [2:0]  rec_pos     = '0;
    logic [39:0] rec_bytes   = '0;
    logic [7:0]  ca_high     = '0;
    logic        awaiting_ca = 1'b0;
    logic        pending_rep = 1'b0;
    bit          seen_ids [ID_COUNT];
    result_t     expected_records [$];

    dab_fig0_3_record_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic void drop_frame();
        rec_pos     = '0;
        rec_bytes   = '0;
        ca_high     = '0;
        awaiting_ca = 1'b0;
        pending_rep = 1'b0;
    endfunction

    function automatic result_t decode_record(logic rep, logic [15:0] ca, logic err, logic shz);
        result_t r;
        r.component_id    = rec_bytes[39:28];
        r.ca_flag         = rec_bytes[24];
        r.dg_flag         = rec_bytes[23];
        r.component_type  = rec_bytes[21:16];
        r.subchannel_id   = rec_bytes[15:10];
        r.pkt_addr        = rec_bytes[9:0];
        r.rfa_value       = rec_bytes[27:25];
        r.rfu_value       = rec_bytes[22];
        r.ca_word         = ca;
        r.ca_length_error = err;
        r.shared_zero     = shz;
        r.repeat_seen     = rep;
        return r;
    endfunction

    function automatic void add_expected(result_t r);
        expected_records.insert(expected_records.size(), r);
    endfunction

    function automatic void parse_byte(logic [7:0] data, logic first, logic last);
        logic [11:0] id;
        logic        rep;
        if (first)
        begin
            drop_frame();
            return;
        end
        if (awaiting_ca)
        begin
            if (rec_pos == 3'd0)
            begin
                ca_high = data;
                rec_pos = 3'd1;
                if (last)
                begin
                    add_expected(decode_record(pending_rep, 16'h0000, 1'b1, 1'b0));
                    drop_frame();
                end
            end
            else
            begin
                add_expected(
                    decode_record(pending_rep, {ca_high, data}, 1'b0, data == 8'h00));
                drop_frame();
            end
            return;
        end
        rec_bytes = {rec_bytes[31:0], data};
        rec_pos   = rec_pos + 3'd1;
        if (rec_pos >= 3'd5)
        begin
            id  = rec_bytes[39:28];
            rep = seen_ids[id];
            // a repeated ID restarts the seen-set with just that ID
            if (rep)
                seen_ids = '{default: 1'b0};
            seen_ids[id] = 1'b1;
            rec_pos = '0;
            if (rec_bytes[24])
            begin
                if (last)
                begin
                    add_expected(decode_record(rep, 16'h0000, 1'b1, 1'b0));
                    drop_frame();
                end
                else
                begin
                    awaiting_ca = 1'b1;
                    pending_rep = rep;
                end
            end
            else
            begin
                add_expected(decode_record(rep, 16'h0000, 1'b0, 1'b0));
                if (last)
                    drop_frame();
            end
        end
        else if (last)
            drop_frame();
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_records.size() == 0)
                begin
                    $error("result beat with none expected, m_tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("component_id", want.component_id, got.component_id);
                    check_field("ca_flag", want.ca_flag, got.ca_flag);
                    check_field("dg_flag", want.dg_flag, got.dg_flag);
                    check_field("component_type", want.component_type, got.component_type);
                    check_field("subchannel_id", want.subchannel_id, got.subchannel_id);
                    check_field("pkt_addr", want.pkt_addr, got.pkt_addr);
                    check_field("rfa_value", want.rfa_value, got.rfa_value);
                    check_field("rfu_value", want.rfu_value, got.rfu_value);
                    check_field("ca_word", want.ca_word, got.ca_word);
                    check_field("ca_length_error", want.ca_length_error, got.ca_length_error);
                    check_field("shared_zero", want.shared_zero, got.shared_zero);
                    check_field("repeat_seen", want.repeat_seen, got.repeat_seen);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold when requested
    initial
    begin : receiver
        int hold;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_tready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic first, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_run(input logic [7:0] bytes [$], input logic last_at_end);
        foreach (bytes[i])
            send_beat(bytes[i], 1'b0, last_at_end && (i == bytes.size() - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_fig();
        beat_t       fig [$];
        int          n_rec;
        int          idx;
        logic [11:0] id;
        logic        ca;
        fig.insert(fig.size(), beat_t'{8'($urandom), 1'b1, 1'b0});
        n_rec = $urandom_range(5, 1);
        for (int r = 0; r < n_rec; r++)
        begin
            // small ID pool so repeats and seen-set restarts happen often
            id = ($urandom_range(99) < 70) ? 12'h5A0 + 12'($urandom_range(11)) : 12'($urandom);
            ca = ($urandom_range(2) == 0);
            fig.insert(fig.size(), beat_t'{id[11:4], 1'b0, 1'b0});
            fig.insert(fig.size(), beat_t'{{id[3:0],
                ($urandom_range(9) == 0) ? 3'($urandom) : 3'b000, ca}, 1'b0, 1'b0});
            repeat (3) fig.insert(fig.size(), beat_t'{8'($urandom), 1'b0, 1'b0});
            if (ca)
            begin
                fig.insert(fig.size(), beat_t'{8'($urandom), 1'b0, 1'b0});
                fig.insert(fig.size(), beat_t'{($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                    1'b0, 1'b0});
            end
        end
        case ($urandom_range(19))
            0, 1:
            begin
                idx = $urandom_range(fig.size() - 1, 1);
                while (fig.size() > idx)
                    fig.pop_back();
            end
            2:
                while (fig.size() > 1)
                    fig.pop_back();
            3:
            begin
                idx = $urandom_range(fig.size() - 1, 1);
                fig[idx].first = 1'($urandom);
                fig[idx].last  = 1'($urandom);
            end
            default: ;
        endcase
        // occasionally no end marker, so the next header drops the tail
        if ($urandom_range(15) != 0)
            fig[fig.size() - 1].last = 1'b1;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(7, 1))
                fig.insert(fig.size(), beat_t'{8'($urandom), 1'b0, 1'b0});
        foreach (fig[i])
            send_beat(fig[i].data, fig[i].first, fig[i].last);
    endtask

    task automatic test_directed();
        // bytes before any header, all fields at max with CA word
        send_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        // same ID again, rfu set, CA shared byte zero
        send_run('{8'hFF, 8'hF1, 8'h40, 8'h00, 8'h00, 8'hAB, 8'h00}, 1'b0);
        // CA cut off with the fifth byte
        send_run('{8'h12, 8'h31, 8'h80, 8'hFC, 8'h03}, 1'b1);
        // CA cut off with its high byte
        send_beat(8'h55, 1'b1, 1'b0);
        send_run('{8'h12, 8'h31, 8'h00, 8'h00, 8'h00, 8'hC4}, 1'b1);
        // header drops a partial record, header with end marker, trailing fragment
        send_beat(8'h00, 1'b1, 1'b0);
        send_run('{8'hAA, 8'hBB}, 1'b0);
        send_beat(8'h77, 1'b1, 1'b1);
        send_run('{8'h01}, 1'b1);
    endtask

    task automatic test_random_figs(input int count);
        int start;
        start = beats_sent;
        while (beats_sent - start < count)
            send_random_fig();
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold_len = HOLD_CYCLES;
        repeat (6) send_random_fig();
        wait_drained();
    endtask

    initial
    begin
        tx_idle_pct = 15;
        rx_idle_pct = 81;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_figs(400);

        tx_idle_pct = 81;
        rx_idle_pct = 15;
        test_random_figs(380);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_figs(420);

        wait_drained();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- dab_fig0_3_record_parser.f -----
+incdir+rtl
rtl/dabf03_pkg.sv
rtl/dabf03_ram.sv
rtl/dab_fig0_3_record_parser.sv
tb/dab_fig0_3_record_parser_tb.sv
